>>> hdl/tle_pkg.sv
`default_nettype none
package tle_pkg;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;

  // Field widths
  localparam int unsigned CAP_W = 7;   // line_capacity and write position
  localparam int unsigned LEN_W = 6;   // line_length and read_index

  // Result sequence kinds handed from control to the output sequencer
  localparam int unsigned OP_W = 3;
  localparam logic [OP_W-1:0] OP_READ     = 3'd0;  // read answer
  localparam logic [OP_W-1:0] OP_ECHO     = 3'd1;  // echo character
  localparam logic [OP_W-1:0] OP_END      = 3'd2;  // CR, LF
  localparam logic [OP_W-1:0] OP_ERASE    = 3'd3;  // BS, space, BS
  localparam logic [OP_W-1:0] OP_ECHO_END = 3'd4;  // echo character, CR, LF

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [7:0]       ch;
    logic [LEN_W-1:0] len;
    logic             in_range;
  } tle_item_t;

endpackage
`default_nettype wire

>>> hdl/terminal_line_editor.sv
// Line editor for a serial terminal with echo. Each input transaction is a
// received character (tuser 0) or a read of one line store entry (tuser 1);
// the block answers with zero to three output transactions, the final one
// marked by tlast. A new input transaction is taken every cycle while the
// decode stage is free; the output side sends one result per cycle while
// out_tready is high, one to three per item (three for backspace and for a
// line ended by capacity). A line ended by capacity also blocks input while
// its zero terminator is written, because the terminator needs the store's
// single write port after the character itself. Reads return the store
// entry written before, zero for an index at or beyond LINE_DEPTH.
// line_capacity is written through cfg_wen/cfg_wdata while idle; reset
// value 64, clamped to 2..LINE_DEPTH. No clearing pass after reset.
`default_nettype none
module terminal_line_editor #(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // rx_byte[7:0], read_index[13:8], zero pad
  input  wire         in_tuser,   // func
  output logic        out_tvalid,
  input  wire         out_tready,
  // tx_byte[7:0], line_done[8], line_length[14:9], line_char[22:15], zero pad
  output logic [23:0] out_tdata,
  output logic        out_tuser,  // result_kind
  output logic        out_tlast,  // last
  input  wire         cfg_wen,
  input  wire  [6:0]  cfg_wdata   // line_capacity
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;
  logic               item_valid;
  logic               item_take;
  tle_pkg::tle_item_t item;

  tle_ctrl #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  tle_store #(
    .DEPTH(LINE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tle_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .mem_rdata  (mem_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> hdl/tle_store.sv
`default_nettype none
module tle_store #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                         clk,
  input  wire                         we,
  input  wire  [$clog2(DEPTH)-1:0]    waddr,
  input  wire  [7:0]                  wdata,
  input  wire                         re,
  input  wire  [$clog2(DEPTH)-1:0]    raddr,
  output logic [7:0]                  rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/tle_ctrl.sv
`default_nettype none
module tle_ctrl #(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [15:0]                        in_tdata,
  input  wire                                in_tuser,
  input  wire                                cfg_wen,
  input  wire  [tle_pkg::CAP_W-1:0]          cfg_wdata,
  output logic                               mem_we,
  output logic [$clog2(LINE_DEPTH)-1:0]      mem_waddr,
  output logic [7:0]                         mem_wdata,
  output logic                               mem_re,
  output logic [$clog2(LINE_DEPTH)-1:0]      mem_raddr,
  output logic                               item_valid,
  output tle_pkg::tle_item_t                 item,
  input  wire                                item_take
);

  localparam int unsigned AW      = $clog2(LINE_DEPTH);
  localparam int unsigned CW      = tle_pkg::CAP_W;
  localparam int unsigned CAP_MAX = (LINE_DEPTH < 127) ? LINE_DEPTH : 127;
  localparam int unsigned RST_CAP = (LINE_DEPTH < 64) ? LINE_DEPTH : 64;

  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      limit_r, limit_nxt;
  logic               term_pend_r, term_pend_nxt;
  logic [CW-1:0]      term_addr_r, term_addr_nxt;
  logic               s1_v_r, s1_v_nxt;
  tle_pkg::tle_item_t s1_item_r, s1_item_nxt;

  logic               accept;
  logic               gen;
  logic [7:0]         rx;
  logic [tle_pkg::LEN_W-1:0] ridx;
  logic [CW-1:0]      pos_inc;
  logic [CW-1:0]      wa;
  logic               wr;
  logic [CW-1:0]      cap_lo;

  assign rx      = in_tdata[7:0];
  assign ridx    = in_tdata[13:8];
  assign pos_inc = pos_r + 1'b1;

  assign in_tready = (!s1_v_r || item_take) && !term_pend_r;
  assign accept    = in_tvalid && in_tready;

  // Clamp the capacity and keep the character limit
  always_comb begin
    cap_lo    = (cfg_wdata < CW'(2)) ? CW'(2) : cfg_wdata;
    limit_nxt = limit_r;
    if (cfg_wen) begin
      limit_nxt = ((32'(cap_lo) > CAP_MAX) ? CW'(CAP_MAX) : cap_lo) - 1'b1;
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    term_pend_nxt = 1'b0;
    term_addr_nxt = term_addr_r;
    gen           = 1'b0;
    wr            = 1'b0;
    wa            = pos_r;
    mem_wdata     = 8'd0;
    mem_re        = 1'b0;
    s1_item_nxt.op       = tle_pkg::OP_READ;
    s1_item_nxt.ch       = rx;
    s1_item_nxt.len      = '0;
    s1_item_nxt.in_range = 32'(ridx) < LINE_DEPTH;

    // Pending write: zero terminator after a line ended by capacity
    if (term_pend_r) begin
      wr = 1'b1;
      wa = term_addr_r;
    end

    if (accept) begin
      if (in_tuser) begin
        gen    = 1'b1;
        mem_re = 1'b1;
      end else if (rx == tle_pkg::CH_CR || rx == tle_pkg::CH_LF) begin
        gen             = 1'b1;
        s1_item_nxt.op  = tle_pkg::OP_END;
        s1_item_nxt.len = pos_r[tle_pkg::LEN_W-1:0];
        wr              = 1'b1;
        pos_nxt         = '0;
      end else if (rx == tle_pkg::CH_BS || rx == tle_pkg::CH_DEL) begin
        if (pos_r != '0) begin
          gen            = 1'b1;
          s1_item_nxt.op = tle_pkg::OP_ERASE;
          pos_nxt        = pos_r - 1'b1;
        end
      end else if (rx >= tle_pkg::CH_SPACE && rx <= tle_pkg::CH_TILDE) begin
        gen       = 1'b1;
        wr        = 1'b1;
        mem_wdata = rx;
        if (pos_inc >= limit_r) begin
          s1_item_nxt.op  = tle_pkg::OP_ECHO_END;
          s1_item_nxt.len = pos_inc[tle_pkg::LEN_W-1:0];
          pos_nxt         = '0;
          term_pend_nxt   = 32'(pos_inc) < LINE_DEPTH;
          term_addr_nxt   = pos_inc;
        end else begin
          s1_item_nxt.op = tle_pkg::OP_ECHO;
          pos_nxt        = pos_inc;
        end
      end
    end

    mem_we    = wr && (32'(wa) < LINE_DEPTH);
    mem_waddr = AW'(wa);
    mem_raddr = AW'(ridx);

    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = gen;
    end else if (item_take) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      limit_r     <= CW'(RST_CAP - 1);
      term_pend_r <= 1'b0;
      s1_v_r      <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      limit_r     <= limit_nxt;
      term_pend_r <= term_pend_nxt;
      s1_v_r      <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    term_addr_r <= term_addr_nxt;
    if (accept) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  assign item_valid = s1_v_r;
  assign item       = s1_item_r;

endmodule
`default_nettype wire

>>> hdl/tle_emit.sv
`default_nettype none
module tle_emit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 item_valid,
  input  tle_pkg::tle_item_t  item,
  output logic                item_take,
  input  wire  [7:0]          mem_rdata,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [23:0]         out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  logic                       busy_r, busy_nxt;
  logic [1:0]                 step_r, step_nxt;
  logic [tle_pkg::OP_W-1:0]   op_r;
  logic [7:0]                 ch_r;
  logic [tle_pkg::LEN_W-1:0]  len_r;
  logic [7:0]                 rchar_r;

  logic                       fire;
  logic                       last_step;
  logic [7:0]                 tx;
  logic                       done;
  logic [tle_pkg::LEN_W-1:0]  len_o;
  logic [7:0]                 char_o;
  logic                       kind;

  // Result fields from the sequence kind and step
  always_comb begin
    tx        = 8'd0;
    done      = 1'b0;
    kind      = 1'b0;
    char_o    = 8'd0;
    last_step = 1'b1;
    unique case (op_r)
      tle_pkg::OP_READ: begin
        kind   = 1'b1;
        char_o = rchar_r;
      end
      tle_pkg::OP_ECHO: begin
        tx = ch_r;
      end
      tle_pkg::OP_END: begin
        done      = 1'b1;
        tx        = (step_r == 2'd0) ? tle_pkg::CH_CR : tle_pkg::CH_LF;
        last_step = (step_r == 2'd1);
      end
      tle_pkg::OP_ERASE: begin
        tx        = (step_r == 2'd1) ? tle_pkg::CH_SPACE : tle_pkg::CH_BS;
        last_step = (step_r == 2'd2);
      end
      tle_pkg::OP_ECHO_END: begin
        done      = (step_r != 2'd0);
        tx        = (step_r == 2'd0) ? ch_r :
                    (step_r == 2'd1) ? tle_pkg::CH_CR : tle_pkg::CH_LF;
        last_step = (step_r == 2'd2);
      end
      default: begin
        tx = 8'd0;
      end
    endcase
    len_o = done ? len_r : '0;
  end

  assign out_tvalid = busy_r;
  assign out_tuser  = kind;
  assign out_tlast  = last_step;
  assign out_tdata  = {1'b0, char_o, len_o, done, tx};

  assign fire      = busy_r && out_tready;
  assign item_take = item_valid && (!busy_r || (fire && last_step));

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (item_take) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
    end else if (fire) begin
      if (last_step) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Capture the read data together with the transaction
  always_ff @(posedge clk) begin
    if (item_take) begin
      op_r    <= item.op;
      ch_r    <= item.ch;
      len_r   <= item.len;
      rchar_r <= item.in_range ? mem_rdata : 8'd0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/tle_checker.sv
`default_nettype none
module tle_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire        out_tuser,
  input wire        out_tlast
);

  // Output register is empty right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Read answer is a single transaction with no transmit content
  a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tlast && out_tdata[7:0] == 8'd0 && !out_tdata[8] && out_tdata[14:9] == 6'd0)
    else $error("malformed read answer");

  // Line end results carry CR then LF
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |->
      !out_tuser && (out_tdata[7:0] == tle_pkg::CH_CR || out_tdata[7:0] == tle_pkg::CH_LF)
      && (out_tlast == (out_tdata[7:0] == tle_pkg::CH_LF)))
    else $error("line end result out of order");

  // After CR the next transaction is the LF of the same line
  a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[8] && !out_tlast |=>
      !out_tvalid || (out_tdata[8] && out_tlast && $stable(out_tdata[14:9])))
    else $error("LF does not follow CR");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

>>> test/line_editor_tb_pkg.sv
`timescale 1ns / 1ps
package line_editor_tb_pkg;

  // What an input transaction asks for (in_tuser)
  typedef enum logic {
    FUNC_CHAR = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  // What an output transaction carries (out_tuser)
  typedef enum logic {
    KIND_TX   = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

endpackage

>>> test/line_editor_checker.sv
`timescale 1ns / 1ps
module line_editor_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [15:0] in_tdata,
  input  wire         in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [23:0] out_tdata,
  input  wire         out_tuser,
  input  wire         out_tlast,
  input  wire         cfg_wen,
  input  wire  [6:0]  cfg_wdata,
  output int          mismatch_count,
  output int          results_pending,
  output logic [63:0] entry_written
);

  localparam int STORE_DEPTH = 64;

  typedef struct {
    line_editor_tb_pkg::kind_t kind;
    logic [7:0]                tx;
    logic                      fin;
    logic                      done;
    logic [5:0]                len;
    logic [7:0]                ch;
  } echo_t;

  echo_t      awaited[$];
  logic [7:0] line_mem [STORE_DEPTH];
  logic [6:0] cursor;
  logic [6:0] capacity;

  function automatic logic [6:0] char_limit(input logic [6:0] cap);
    logic [6:0] c;
    c = cap;
    if (c < 7'd2) c = 7'd2;
    if (c > 7'(STORE_DEPTH)) c = 7'(STORE_DEPTH);
    return c - 7'd1;
  endfunction

  function automatic void queue_result(input line_editor_tb_pkg::kind_t kind,
                                       input logic [7:0] tx,
                                       input logic fin, input logic done,
                                       input logic [5:0] len, input logic [7:0] ch);
    echo_t r;
    r.kind = kind;
    r.tx   = tx;
    r.fin  = fin;
    r.done = done;
    r.len  = len;
    r.ch   = ch;
    awaited.push_back(r);
  endfunction

  // Terminate the line, emit CR and LF with its length, rewind the cursor
  function automatic void close_line();
    line_mem[cursor[5:0]] = 8'd0;
    entry_written[cursor[5:0]] = 1'b1;
    queue_result(line_editor_tb_pkg::KIND_TX, tle_pkg::CH_CR, 1'b0, 1'b1, cursor[5:0], 8'd0);
    queue_result(line_editor_tb_pkg::KIND_TX, tle_pkg::CH_LF, 1'b1, 1'b1, cursor[5:0], 8'd0);
    cursor = '0;
  endfunction

  function automatic void predict_item(input logic func, input logic [7:0] ch,
                                       input logic [5:0] idx);
    if (func == line_editor_tb_pkg::FUNC_READ) begin
      queue_result(line_editor_tb_pkg::KIND_READ, 8'd0, 1'b1, 1'b0, 6'd0, line_mem[idx]);
    end else if (ch == tle_pkg::CH_CR || ch == tle_pkg::CH_LF) begin
      close_line();
    end else if (ch == tle_pkg::CH_BS || ch == tle_pkg::CH_DEL) begin
      // erase at column zero produces nothing
      if (cursor != '0) begin
        cursor = cursor - 7'd1;
        queue_result(line_editor_tb_pkg::KIND_TX, tle_pkg::CH_BS, 1'b0, 1'b0, 6'd0, 8'd0);
        queue_result(line_editor_tb_pkg::KIND_TX, tle_pkg::CH_SPACE, 1'b0, 1'b0, 6'd0, 8'd0);
        queue_result(line_editor_tb_pkg::KIND_TX, tle_pkg::CH_BS, 1'b1, 1'b0, 6'd0, 8'd0);
      end
    end else if (ch >= tle_pkg::CH_SPACE && ch <= tle_pkg::CH_TILDE) begin
      line_mem[cursor[5:0]] = ch;
      entry_written[cursor[5:0]] = 1'b1;
      cursor = cursor + 7'd1;
      // limit is checked only after the store, so a lowered capacity ends here
      if (cursor >= char_limit(capacity)) begin
        queue_result(line_editor_tb_pkg::KIND_TX, ch, 1'b0, 1'b0, 6'd0, 8'd0);
        close_line();
      end else begin
        queue_result(line_editor_tb_pkg::KIND_TX, ch, 1'b1, 1'b0, 6'd0, 8'd0);
      end
    end
    // anything else is dropped
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    echo_t want;
    if (!rst_n) begin
      awaited.delete();
      cursor = '0;
      capacity = 7'd64;
      entry_written = '0;
      mismatch_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited.size() == 0) begin
          $error("result with nothing awaited: tuser %0d tdata %h", out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          want = awaited.pop_front();
          compare_field("result_kind", want.kind, out_tuser);
          compare_field("tx_byte", want.tx, out_tdata[7:0]);
          compare_field("last", want.fin, out_tlast);
          compare_field("line_done", want.done, out_tdata[8]);
          compare_field("line_length", want.len, out_tdata[14:9]);
          compare_field("line_char", want.ch, out_tdata[22:15]);
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata[7:0], in_tdata[13:8]);
      if (cfg_wen) capacity = cfg_wdata;
    end
    results_pending = awaited.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_wen    = 1'b0;
  logic [6:0]  cfg_wdata  = '0;

  int          mismatch_count;
  int          results_pending;
  logic [63:0] entry_written;

  bit          steady = 1'b0;
  int          items_in = 0;
  int          results_out = 0;
  int          cap_writes = 0;
  int          quiet = 0;

  always #10 clk = ~clk;

  terminal_line_editor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  line_editor_checker line_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .entry_written   (entry_written)
  );

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) items_in++;
      if (out_tvalid && out_tready) results_out++;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                   QUIET_LIMIT, results_pending);
          $display("** terminal_line_editor: FAILED **");
          $finish;
        end
      end
    end
  end

  // Called and returns at a falling edge; tvalid stays high for the next item
  task automatic send_item(input line_editor_tb_pkg::func_t func, input logic [7:0] ch,
                           input logic [5:0] idx);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {2'b00, idx, ch};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic type_char(input logic [7:0] ch);
    send_item(line_editor_tb_pkg::FUNC_CHAR, ch, 6'($urandom_range(0, 63)));
  endtask

  task automatic read_entry(input logic [5:0] idx);
    send_item(line_editor_tb_pkg::FUNC_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  // Only entries that have been written are ever read back
  task automatic read_random();
    logic [5:0] idx;
    idx = 6'($urandom_range(0, 63));
    while (!entry_written[idx]) idx--;
    read_entry(idx);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [6:0] cap);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    cap_writes++;
  endtask

  // Printables with occasional erases, usually closed by CR or LF
  task automatic type_line(input int room, input bit long_line, output int used);
    int len;
    if (long_line) len = 63;
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
    else len = $urandom_range(1, 12);
    used = 0;
    for (int i = 0; i < len && used < room; i++) begin
      if (!long_line && i > 0 && $urandom_range(0, 9) == 0)
        type_char(($urandom_range(0, 1) != 0) ? tle_pkg::CH_BS : tle_pkg::CH_DEL);
      else
        type_char(8'($urandom_range(32, 126)));
      used++;
    end
    if (used < room && $urandom_range(0, 99) < 85) begin
      type_char(($urandom_range(0, 1) != 0) ? tle_pkg::CH_CR : tle_pkg::CH_LF);
      used++;
    end
  endtask

  initial begin
    logic [6:0] phase_cap [7];
    int         phase_items [7];
    int         spent;
    int         used;
    int         pick;
    logic [7:0] noise;
    phase_cap   = '{7'd2, 7'd127, 7'd5, 7'd0, 7'd33, 7'd1, 7'd64};
    phase_items = '{10, 66, 12, 8, 12, 6, 20};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // erase on an empty line, then bytes that must be dropped
    type_char(tle_pkg::CH_BS);
    type_char(tle_pkg::CH_DEL);
    type_char(8'd0);
    type_char(8'd31);
    type_char(8'd128);
    type_char(8'd255);
    type_char(8'd9);
    // printable extremes, both erase codes, CR close, read back incl. terminator
    type_char(tle_pkg::CH_SPACE);
    type_char(tle_pkg::CH_TILDE);
    type_char("A");
    type_char(tle_pkg::CH_DEL);
    type_char(tle_pkg::CH_BS);
    type_char("z");
    type_char(tle_pkg::CH_CR);
    read_entry(6'd0);
    read_entry(6'd1);
    read_entry(6'd2);
    type_char(tle_pkg::CH_LF);
    // leave a line open, then shrink capacity below its length
    repeat (8) type_char(8'($urandom_range(32, 126)));
    set_capacity(7'd4);
    type_char(8'($urandom_range(32, 126)));
    read_entry(6'd9);

    foreach (phase_cap[p]) begin
      set_capacity(phase_cap[p]);
      steady = (phase_cap[p] == 7'd127);
      spent = 0;
      while (spent < phase_items[p]) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          type_line(phase_items[p] - spent, (phase_cap[p] == 7'd127) && spent == 0, used);
          spent += used;
        end else if (pick < 82) begin
          read_random();
          spent++;
        end else if (pick < 96) begin
          noise = 8'($urandom_range(0, 255));
          type_char(noise);
          if ((noise >= tle_pkg::CH_SPACE && noise <= tle_pkg::CH_DEL) ||
              noise == tle_pkg::CH_BS || noise == tle_pkg::CH_CR ||
              noise == tle_pkg::CH_LF) spent++;
        end else begin
          // hold off until every pending result is out
          drain();
        end
      end
      steady = 1'b0;
    end

    drain();
    $display("Covered %0d input and %0d output transactions over %0d capacity writes,",
             items_in, results_out, cap_writes);
    $display("with out-of-range capacities, column-zero erases, dropped bytes and full lines.");
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("** terminal_line_editor: PASSED **");
    end else begin
      $display("** terminal_line_editor: FAILED **");
    end
    $finish;
  end

endmodule
